@@ hdl/vpgm_pkg.sv @@
// Shared constants and types for the VAD pad and gap merge mask unit.
package vpgm_pkg;

  localparam int unsigned CFG_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEAD_PAD  = 2'd0,
    CFG_TAIL_PAD  = 2'd1,
    CFG_MERGE_GAP = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] lead_pad;
    logic [CFG_W-1:0] tail_pad;
    logic [CFG_W-1:0] merge_gap;
  } cfg_t;

  typedef struct packed {
    logic masked;
    logic center_speech;
  } verdict_t;

endpackage

@@ hdl/vad_pad_and_gap_merge_mask_unit.sv @@
// Top level of the VAD pad and gap merge mask unit.
// Takes one voice-activity flag a beat and answers for the frame WINDOW beats back: one
// frame a cycle sustained while m_axis_tready holds, result registered when the beat is
// taken; the first WINDOW beats after reset give no result. The answer comes from a chain
// of WINDOW+1 cells that shift once per accepted beat, each carrying its flag, the
// distance to the nearest earlier speech and the distance to the nearest later speech; a single
// output register holds the result until it is taken. Drain the tail with non-speech frames.
module vad_pad_and_gap_merge_mask_unit #(
  parameter int unsigned WINDOW = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vpgm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vpgm_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [0] is_speech
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata    // [0] masked, [1] center_speech
);
  import vpgm_pkg::*;

  localparam int unsigned DW = $clog2(WINDOW + 1);
  localparam int unsigned NW = $clog2(WINDOW + 2);

  cfg_t          cfg_q;
  logic [NW-1:0] seen_q, seen_d;
  logic          accept, fire;
  logic          out_valid_q;
  verdict_t      out_q, verdict;

  logic          flag   [WINDOW+1];
  logic [DW-1:0] back   [WINDOW+1];
  logic [DW-1:0] ahead  [WINDOW+1];
  logic [DW-1:0] ahead_d[WINDOW+1];
  logic [DW-1:0] back_in;
  logic          new_speech;

  assign new_speech    = s_axis_tdata[0];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = accept && (seen_q >= NW'(WINDOW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEAD_PAD:  cfg_q.lead_pad  <= cfg_data_i;
        CFG_TAIL_PAD:  cfg_q.tail_pad  <= cfg_data_i;
        CFG_MERGE_GAP: cfg_q.merge_gap <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    seen_d = seen_q;
    if (accept && seen_q <= NW'(WINDOW)) begin
      seen_d = seen_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  always_comb begin
    if (flag[0]) begin
      back_in = DW'(1);
    end else if (back[0] == '0 || back[0] == DW'(WINDOW)) begin
      back_in = '0;
    end else begin
      back_in = back[0] + DW'(1);
    end
  end

  for (genvar k = 0; k <= WINDOW; k++) begin : g_cell
    vpgm_cell #(
      .DW (DW),
      .POS(k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (accept),
      .new_speech_i(new_speech),
      .prev_flag_i ((k == 0) ? new_speech : flag[(k == 0) ? 0 : k-1]),
      .prev_back_i ((k == 0) ? back_in : back[(k == 0) ? 0 : k-1]),
      .prev_ahead_i((k == 0) ? '0 : ahead[(k == 0) ? 0 : k-1]),
      .flag_o      (flag[k]),
      .back_o      (back[k]),
      .ahead_o     (ahead[k]),
      .ahead_d_o   (ahead_d[k])
    );
  end

  vpgm_decide #(
    .DW(DW)
  ) u_decide (
    .center_flag_i(flag[WINDOW-1]),
    .back_i       (back[WINDOW-1]),
    .ahead_i      (ahead_d[WINDOW]),
    .cfg_i        (cfg_q),
    .verdict_o    (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.center_speech, out_q.masked};

endmodule

@@ hdl/vpgm_cell.sv @@
// One frame cell of the history chain: flag, distance back and distance ahead to speech.
module vpgm_cell #(
  parameter int unsigned DW  = 7,
  parameter int unsigned POS = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          new_speech_i,
  input  logic          prev_flag_i,
  input  logic [DW-1:0] prev_back_i,
  input  logic [DW-1:0] prev_ahead_i,
  output logic          flag_o,
  output logic [DW-1:0] back_o,
  output logic [DW-1:0] ahead_o,
  output logic [DW-1:0] ahead_d_o
);

  logic          flag_q;
  logic [DW-1:0] back_q;
  logic [DW-1:0] ahead_q, ahead_d;

  always_comb begin
    if (prev_ahead_i != '0) begin
      ahead_d = prev_ahead_i;
    end else if (new_speech_i) begin
      ahead_d = DW'(POS);
    end else begin
      ahead_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q  <= 1'b0;
      back_q  <= '0;
      ahead_q <= '0;
    end else if (shift_i) begin
      flag_q  <= prev_flag_i;
      back_q  <= prev_back_i;
      ahead_q <= ahead_d;
    end
  end

  assign flag_o    = flag_q;
  assign back_o    = back_q;
  assign ahead_o   = ahead_q;
  assign ahead_d_o = ahead_d;

endmodule

@@ hdl/vpgm_decide.sv @@
// Mask decision for the centre frame from its distances to speech on either side.
module vpgm_decide #(
  parameter int unsigned DW = 7
) (
  input  logic              center_flag_i,
  input  logic [DW-1:0]     back_i,
  input  logic [DW-1:0]     ahead_i,
  input  vpgm_pkg::cfg_t    cfg_i,
  output vpgm_pkg::verdict_t verdict_o
);
  import vpgm_pkg::*;

  localparam int unsigned CW = ((DW > CFG_W) ? DW : CFG_W) + 1;

  logic [CW-1:0] back_x, ahead_x, gap;
  logic          back_hit, ahead_hit, keep_pad, keep_merge;

  always_comb begin
    back_x     = CW'(back_i);
    ahead_x    = CW'(ahead_i);
    back_hit   = back_i != '0;
    ahead_hit  = ahead_i != '0;
    gap        = back_x + ahead_x - CW'(1);
    keep_pad   = (back_hit && back_x <= CW'(cfg_i.tail_pad)) ||
                 (ahead_hit && ahead_x <= CW'(cfg_i.lead_pad));
    keep_merge = back_hit && ahead_hit && gap <= CW'(cfg_i.merge_gap);
    verdict_o.center_speech = center_flag_i;
    verdict_o.masked        = !center_flag_i && !keep_pad && !keep_merge;
  end

endmodule

@@ hdl/vpgm_checker.sv @@
// Port-level checks for the VAD pad and gap merge mask unit, bound to the top level.
module vpgm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input beat changed while stalled");

  a_speech_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("speech frame masked");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result beat without an input beat");

endmodule

bind vad_pad_and_gap_merge_mask_unit vpgm_checker u_vpgm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
